// ===== design/lru_block_buffer_cache_macros.svh =====
// ----------------------------------------------------------------------------
// lru block buffer cache assertion macros
// concurrent assertion wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_BUFFER_CACHE_MACROS_SVH
`define LRU_BLOCK_BUFFER_CACHE_MACROS_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define LBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LBC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== design/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg
// shared types and codes of the lru block buffer cache
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 32;
    localparam logic [5:0] COUNT_MAX = 6'd63;

    localparam logic [2:0] MODE_GET       = 3'd0;
    localparam logic [2:0] MODE_RELEASE   = 3'd1;
    localparam logic [2:0] MODE_PIN       = 3'd2;
    localparam logic [2:0] MODE_UNPIN     = 3'd3;
    localparam logic [2:0] MODE_WRITE     = 3'd4;
    localparam logic [2:0] MODE_DISK_DONE = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BUSY       = 3'd1;
    localparam logic [2:0] ST_NO_BUFFER  = 3'd2;
    localparam logic [2:0] ST_NOT_LOCKED = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW  = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic apply_get;
        logic apply_op;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
    } t_sts;

endpackage

// ===== design/lru_block_buffer_cache.sv =====
// get returns its result after the load, the tag scan over all slots and the update step,
//   the other modes after the load and the update step
// throughput: one request at a time; get is bound by the one-slot-per-cycle tag scan
// o_done pulses for one cycle with the result; the receiver cannot stall
// reset (synchronous, active low) clears all marks and counts, ranks to slot order
// ----------------------------------------------------------------------------
// lru_block_buffer_cache
// tag table of buffer slots with lock, dirty, valid marks, counts and lru ranks
// ----------------------------------------------------------------------------
`include "lru_block_buffer_cache_macros.svh"

module lru_block_buffer_cache #(
    parameter int unsigned SLOT_COUNT = lbc_pkg::SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: block_base
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // request
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_device,
    input  logic [31:0] i_block_number,
    input  logic [4:0]  i_slot,
    // result
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [4:0]  o_granted_slot,
    output logic        o_need_disk_read,
    output logic        o_need_disk_write
);
    import lbc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: idle, scan (get only), then an update step
    lbc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_is_get (i_mode == MODE_GET),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    // slot table, tag memory and result registers
    lbc_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_mode            (i_mode),
        .i_device          (i_device),
        .i_block_number    (i_block_number),
        .i_slot            (i_slot),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_granted_slot    (o_granted_slot),
        .o_need_disk_read  (o_need_disk_read),
        .o_need_disk_write (o_need_disk_write)
    );

    // the result arrives as the sequencer returns to idle
    `LBC_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |-> !busy, "result while busy")
    // an accepted request always occupies the block next cycle
    `LBC_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "request dropped")
    // disk flags only ride on a successful result
    `LBC_ASSERT(a_wr_ok, i_clk, i_rst_n, (o_done && o_need_disk_write) |-> (o_status == ST_OK), "stray disk write")
    `LBC_ASSERT(a_rd_ok, i_clk, i_rst_n, (o_done && o_need_disk_read) |-> (o_status == ST_OK), "stray disk read")
    // reset leaves no pending result
    `LBC_ASSERT_ALWAYS(a_rst_quiet, i_clk, !$past(i_rst_n) |-> !o_done, "result after reset")

endmodule

// ===== design/lbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbc_ctrl
// request sequencer: lookup scan for get, single update step otherwise
// ----------------------------------------------------------------------------
module lbc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_is_get,
    input  lbc_pkg::t_sts i_sts,
    output lbc_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import lbc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_GET  = 2'd2;
    localparam logic [1:0] S_OP   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_is_get ? S_SCAN : S_OP;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) n_state = S_GET;
            end
            S_GET: begin
                o_cmd.apply_get = 1'b1;
                n_state         = S_IDLE;
            end
            S_OP: begin
                o_cmd.apply_op = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== design/lbc_datapath.sv =====
// ----------------------------------------------------------------------------
// lbc_datapath
// slot table, tag memory, scan compare and victim select, result registers
// ----------------------------------------------------------------------------
module lbc_datapath #(
    parameter int unsigned SLOT_COUNT = lbc_pkg::SLOT_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  logic [2:0]    i_mode,
    input  logic [7:0]    i_device,
    input  logic [31:0]   i_block_number,
    input  logic [4:0]    i_slot,
    input  lbc_pkg::t_cmd i_cmd,
    output lbc_pkg::t_sts o_sts,
    output logic          o_done,
    output logic [2:0]    o_status,
    output logic [4:0]    o_granted_slot,
    output logic          o_need_disk_read,
    output logic          o_need_disk_write
);
    import lbc_pkg::*;

    localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SW-1:0] LAST = SW'(SLOT_COUNT - 1);

    // request registers
    logic [31:0]   r_base;
    logic [2:0]    r_mode;
    logic [7:0]    r_dev;
    logic [31:0]   r_blk;
    logic [4:0]    r_slot;

    // tag memory, gated by present bits
    logic [7:0]    mem_dev [SLOT_COUNT];
    logic [31:0]   mem_blk [SLOT_COUNT];

    // per-slot flags
    logic          r_present [SLOT_COUNT];
    logic          r_valid   [SLOT_COUNT];
    logic          r_dirty   [SLOT_COUNT];
    logic          r_lock    [SLOT_COUNT];
    logic [5:0]    r_count   [SLOT_COUNT];
    logic [SW-1:0] r_rank    [SLOT_COUNT];

    // scan state
    logic [SW-1:0] r_issue;
    logic [SW-1:0] r_cmp_idx;
    logic          r_cmp_vld;
    logic [7:0]    r_rd_dev;
    logic [31:0]   r_rd_blk;
    logic          r_hit_found;
    logic [SW-1:0] r_hit_idx;
    logic          r_vic_found;
    logic [SW-1:0] r_vic_idx;
    logic [SW-1:0] r_vic_rank;

    logic [SW-1:0] w_slot_idx;
    logic          w_slot_ok;
    logic [SW-1:0] w_sel;
    logic          w_lock;
    logic          w_valid;
    logic          w_dirty;
    logic [5:0]    w_count;
    logic [SW-1:0] w_rank;
    logic          w_match;
    logic          w_elig;

    assign w_slot_idx = SW'(r_slot);
    assign w_slot_ok  = (32'(r_slot) < SLOT_COUNT);

    // single read address into the flag table
    always_comb begin
        priority if (i_cmd.scan)  w_sel = r_cmp_idx;
        else if (i_cmd.apply_get) w_sel = r_hit_found ? r_hit_idx : r_vic_idx;
        else                      w_sel = w_slot_idx;
    end

    assign w_lock  = r_lock[w_sel];
    assign w_valid = r_valid[w_sel];
    assign w_dirty = r_dirty[w_sel];
    assign w_count = r_count[w_sel];
    assign w_rank  = r_rank[w_sel];

    assign w_match = r_present[w_sel] && (r_rd_dev == r_dev) && (r_rd_blk == r_blk);
    assign w_elig  = !w_lock && !w_dirty && (w_count == 6'd0);

    assign o_sts.scan_done = r_cmp_vld && (r_cmp_idx == LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    // request capture and scan pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld   <= 1'b0;
            r_hit_found <= 1'b0;
            r_vic_found <= 1'b0;
            r_issue     <= '0;
        end else if (i_cmd.load) begin
            r_mode      <= i_mode;
            r_dev       <= i_device;
            r_blk       <= i_block_number + r_base;
            r_slot      <= i_slot;
            r_issue     <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit_found <= 1'b0;
            r_vic_found <= 1'b0;
        end else if (i_cmd.scan) begin
            r_rd_dev  <= mem_dev[r_issue];
            r_rd_blk  <= mem_blk[r_issue];
            r_cmp_idx <= r_issue;
            r_cmp_vld <= 1'b1;
            if (r_issue != LAST) r_issue <= r_issue + 1'b1;
            if (r_cmp_vld) begin
                if (w_match) begin
                    r_hit_found <= 1'b1;
                    r_hit_idx   <= r_cmp_idx;
                end
                if (w_elig && (!r_vic_found || (w_rank < r_vic_rank))) begin
                    r_vic_found <= 1'b1;
                    r_vic_idx   <= r_cmp_idx;
                    r_vic_rank  <= w_rank;
                end
            end
        end
    end

    // tag memory write on a claimed slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply_get && !r_hit_found && r_vic_found) begin
            mem_dev[r_vic_idx] <= r_dev;
            mem_blk[r_vic_idx] <= r_blk;
        end
    end

    // flag table update and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_present[i] <= 1'b0;
                r_valid[i]   <= 1'b0;
                r_dirty[i]   <= 1'b0;
                r_lock[i]    <= 1'b0;
                r_count[i]   <= '0;
                r_rank[i]    <= SW'(i);
            end
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.apply_get || i_cmd.apply_op;
            if (i_cmd.apply_get || i_cmd.apply_op) begin
                o_status          <= ST_OK;
                o_granted_slot    <= r_slot;
                o_need_disk_read  <= 1'b0;
                o_need_disk_write <= 1'b0;
            end
            if (i_cmd.apply_get) begin
                if (r_hit_found) begin
                    if (w_lock) begin
                        o_status <= ST_BUSY;
                    end else begin
                        r_lock[w_sel] <= 1'b1;
                        if (w_count < COUNT_MAX) r_count[w_sel] <= w_count + 1'b1;
                        o_granted_slot   <= 5'(w_sel);
                        o_need_disk_read <= !w_valid;
                    end
                end else if (r_vic_found) begin
                    r_present[w_sel] <= 1'b1;
                    r_valid[w_sel]   <= 1'b0;
                    r_dirty[w_sel]   <= 1'b0;
                    r_lock[w_sel]    <= 1'b1;
                    r_count[w_sel]   <= 6'd1;
                    o_granted_slot   <= 5'(w_sel);
                    o_need_disk_read <= 1'b1;
                end else begin
                    o_status <= ST_NO_BUFFER;
                end
            end
            if (i_cmd.apply_op && w_slot_ok) begin
                unique case (r_mode)
                    MODE_RELEASE: begin
                        if (!w_lock) begin
                            o_status <= ST_NOT_LOCKED;
                        end else begin
                            r_lock[w_sel] <= 1'b0;
                            if (w_count == 6'd0) begin
                                o_status <= ST_UNDERFLOW;
                            end else begin
                                r_count[w_sel] <= w_count - 1'b1;
                                if (w_count == 6'd1) begin
                                    // move to most recent, younger slots shift down
                                    for (int i = 0; i < SLOT_COUNT; i++) begin
                                        if (r_rank[i] > w_rank) r_rank[i] <= r_rank[i] - 1'b1;
                                    end
                                    r_rank[w_sel] <= LAST;
                                end
                            end
                        end
                    end
                    MODE_PIN: begin
                        if (w_count < COUNT_MAX) r_count[w_sel] <= w_count + 1'b1;
                    end
                    MODE_UNPIN: begin
                        if (w_count == 6'd0) o_status <= ST_UNDERFLOW;
                        else                 r_count[w_sel] <= w_count - 1'b1;
                    end
                    MODE_WRITE: begin
                        if (!w_lock) begin
                            o_status <= ST_NOT_LOCKED;
                        end else begin
                            r_dirty[w_sel]    <= 1'b1;
                            o_need_disk_write <= 1'b1;
                        end
                    end
                    MODE_DISK_DONE: begin
                        r_valid[w_sel] <= 1'b1;
                        r_dirty[w_sel] <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== test/tb_lru_block_buffer_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_block_buffer_cache
// drives a directed table of requests and then random request streams into
// the buffer cache, predicts each result from a behavioral copy of the slot
// table and compares it field by field as it comes out
// ----------------------------------------------------------------------------
module tb_lru_block_buffer_cache;
    import lbc_pkg::*;

    localparam int unsigned NSLOT = 32;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam int unsigned RANDOM_REQUESTS = 970;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        start;
    logic        busy;
    logic [2:0]  i_mode;
    logic [7:0]  i_device;
    logic [31:0] i_block_number;
    logic [4:0]  i_slot;
    logic        o_done;
    logic [2:0]  o_status;
    logic [4:0]  o_granted_slot;
    logic        o_need_disk_read;
    logic        o_need_disk_write;

    // one expected answer
    typedef struct packed {
        logic [2:0] status;
        logic [4:0] granted;
        logic       rd;
        logic       wr;
    } t_answer;

    // one row of the directed table; has_fixed marks a typed-in answer
    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  device;
        logic [31:0] block;
        logic [4:0]  slot;
        logic        has_fixed;
        t_answer     fixed;
    } t_row;

    // shadow of the slot table
    logic [7:0]  sh_dev     [NSLOT];
    logic [31:0] sh_blk     [NSLOT];
    logic        sh_present [NSLOT];
    logic        sh_valid   [NSLOT];
    logic        sh_dirty   [NSLOT];
    logic        sh_lock    [NSLOT];
    logic [5:0]  sh_count   [NSLOT];
    logic [4:0]  sh_rank    [NSLOT];
    logic [31:0] sh_base;

    t_answer answers_due[$];
    int      fail_count = 0;

    lru_block_buffer_cache dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .start             (start),
        .busy              (busy),
        .i_mode            (i_mode),
        .i_device          (i_device),
        .i_block_number    (i_block_number),
        .i_slot            (i_slot),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_granted_slot    (o_granted_slot),
        .o_need_disk_read  (o_need_disk_read),
        .o_need_disk_write (o_need_disk_write)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // shadow table back to its reset state
    task automatic table_reset();
        for (int i = 0; i < NSLOT; i++) begin
            sh_dev[i] = '0;
            sh_blk[i] = '0;
            sh_present[i] = 1'b0;
            sh_valid[i] = 1'b0;
            sh_dirty[i] = 1'b0;
            sh_lock[i] = 1'b0;
            sh_count[i] = '0;
            sh_rank[i] = 5'(i);
        end
        sh_base = '0;
    endtask

    // compute the answer to one request and update the shadow table
    function automatic t_answer cache_answer(logic [2:0] mode, logic [7:0] dev,
                                             logic [31:0] blk_in, logic [4:0] s);
        t_answer a;
        logic [31:0] blk;
        int hit;
        int victim;
        logic [4:0] old_rank;
        a = '{status: ST_OK, granted: s, rd: 1'b0, wr: 1'b0};
        blk = blk_in + sh_base;
        hit = -1;
        victim = -1;
        case (mode)
            MODE_GET: begin
                for (int i = 0; i < NSLOT; i++)
                    if (sh_present[i] && sh_dev[i] == dev && sh_blk[i] == blk) hit = i;
                if (hit >= 0) begin
                    if (sh_lock[hit]) begin
                        a.status = ST_BUSY;
                    end else begin
                        sh_lock[hit] = 1'b1;
                        if (sh_count[hit] != COUNT_MAX) sh_count[hit]++;
                        a.granted = 5'(hit);
                        a.rd = !sh_valid[hit];
                    end
                end else begin
                    // least recent slot that is free to take
                    for (int i = 0; i < NSLOT; i++) begin
                        if (sh_lock[i] || sh_dirty[i] || sh_count[i] != 0) continue;
                        if (victim < 0 || sh_rank[i] < sh_rank[victim]) victim = i;
                    end
                    if (victim < 0) begin
                        a.status = ST_NO_BUFFER;
                    end else begin
                        sh_dev[victim] = dev;
                        sh_blk[victim] = blk;
                        sh_present[victim] = 1'b1;
                        sh_valid[victim] = 1'b0;
                        sh_dirty[victim] = 1'b0;
                        sh_lock[victim] = 1'b1;
                        sh_count[victim] = 6'd1;
                        a.granted = 5'(victim);
                        a.rd = 1'b1;
                    end
                end
            end
            MODE_RELEASE: begin
                if (!sh_lock[s]) begin
                    a.status = ST_NOT_LOCKED;
                end else begin
                    sh_lock[s] = 1'b0;
                    if (sh_count[s] == 0) begin
                        a.status = ST_UNDERFLOW;
                    end else begin
                        sh_count[s]--;
                        if (sh_count[s] == 0) begin
                            old_rank = sh_rank[s];
                            for (int i = 0; i < NSLOT; i++)
                                if (sh_rank[i] > old_rank) sh_rank[i]--;
                            sh_rank[s] = 5'(NSLOT - 1);
                        end
                    end
                end
            end
            MODE_PIN: begin
                if (sh_count[s] != COUNT_MAX) sh_count[s]++;
            end
            MODE_UNPIN: begin
                if (sh_count[s] == 0) a.status = ST_UNDERFLOW;
                else sh_count[s]--;
            end
            MODE_WRITE: begin
                if (!sh_lock[s]) begin
                    a.status = ST_NOT_LOCKED;
                end else begin
                    sh_dirty[s] = 1'b1;
                    a.wr = 1'b1;
                end
            end
            MODE_DISK_DONE: begin
                sh_valid[s] = 1'b1;
                sh_dirty[s] = 1'b0;
            end
            default: ;  // spare modes do nothing
        endcase
        return a;
    endfunction

    // one request: hold start until accepted, predict at the accepting edge
    task automatic send_request(logic [2:0] mode, logic [7:0] dev, logic [31:0] blk,
                                logic [4:0] s, logic has_fixed, t_answer fixed);
        t_answer a;
        start <= 1'b1;
        i_mode <= mode;
        i_device <= dev;
        i_block_number <= blk;
        i_slot <= s;
        do @(posedge i_clk); while (busy);
        a = cache_answer(mode, dev, blk, s);
        if (has_fixed && a != fixed) begin
            $error("directed row answer expected %0h got %0h", fixed, a);
            fail_count++;
        end
        answers_due.push_back(a);
    endtask

    // end start after a request unless another follows right away
    task automatic drop_start();
        start <= 1'b0;
    endtask

    // wait for all answers, then the worst-case get latency before config
    task automatic drain();
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (NSLOT + 8) @(posedge i_clk);
    endtask

    task automatic write_base(logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sh_base = v;
    endtask

    // result checker, samples at the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        t_answer exp_a;
        if (i_rst_n && o_done) begin
            if (answers_due.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                exp_a = answers_due.pop_front();
                if (o_status !== exp_a.status) begin
                    $error("status expected %0d got %0d", exp_a.status, o_status);
                    fail_count++;
                end
                if (o_granted_slot !== exp_a.granted) begin
                    $error("granted_slot expected %0d got %0d", exp_a.granted,
                           o_granted_slot);
                    fail_count++;
                end
                if (o_need_disk_read !== exp_a.rd) begin
                    $error("need_disk_read expected %0d got %0d", exp_a.rd,
                           o_need_disk_read);
                    fail_count++;
                end
                if (o_need_disk_write !== exp_a.wr) begin
                    $error("need_disk_write expected %0d got %0d", exp_a.wr,
                           o_need_disk_write);
                    fail_count++;
                end
            end
        end
    end

    // hard limit on the whole run
    initial begin
        #40ms;
        $display("Verification failed");
        $finish;
    end

    // random content: an independent mix of get/write/done/release/pin/unpin requests over a small
    // tag pool so hits, busy and no_buffer can occur, plus noise
    task automatic random_request(output logic [2:0] m, output logic [7:0] d,
                                  output logic [31:0] b, output logic [4:0] s);
        int pick;
        pick = $urandom_range(0, 99);
        d = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        b = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 40));
        s = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
        // aim slot ops mostly at locked or referenced slots
        for (int k = 0; k < 4; k++) begin
            int c;
            c = $urandom_range(0, NSLOT - 1);
            if (sh_lock[c] || sh_count[c] != 0) begin
                s = 5'(c);
                break;
            end
        end
        if (pick < 35) m = MODE_GET;
        else if (pick < 55) m = MODE_RELEASE;
        else if (pick < 63) m = MODE_PIN;
        else if (pick < 71) m = MODE_UNPIN;
        else if (pick < 83) m = MODE_WRITE;
        else if (pick < 96) m = MODE_DISK_DONE;
        else m = 3'($urandom_range(6, 7));
    endtask

    initial begin
        t_row rows[$];
        logic [2:0]  m;
        logic [7:0]  d;
        logic [31:0] b;
        logic [4:0]  s;
        int sent;
        int burst;
        t_answer none;
        none = '0;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        start = 1'b0;
        i_mode = '0;
        i_device = '0;
        i_block_number = '0;
        i_slot = '0;
        table_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; fixed answers only where obvious after reset
        rows.push_back('{MODE_RELEASE, 8'd0, 32'd0, 5'd3, 1'b1,
                         '{ST_NOT_LOCKED, 5'd3, 1'b0, 1'b0}});
        rows.push_back('{MODE_UNPIN, 8'd0, 32'd0, 5'd31, 1'b1,
                         '{ST_UNDERFLOW, 5'd31, 1'b0, 1'b0}});
        rows.push_back('{MODE_WRITE, 8'd0, 32'd0, 5'd0, 1'b1,
                         '{ST_NOT_LOCKED, 5'd0, 1'b0, 1'b0}});
        rows.push_back('{MODE_GET, 8'd0, 32'd0, 5'd9, 1'b1,
                         '{ST_OK, 5'd0, 1'b1, 1'b0}});
        rows.push_back('{MODE_GET, 8'd0, 32'd0, 5'd9, 1'b1,
                         '{ST_BUSY, 5'd9, 1'b0, 1'b0}});
        rows.push_back('{MODE_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31, 1'b1,
                         '{ST_OK, 5'd1, 1'b1, 1'b0}});
        rows.push_back('{MODE_WRITE, 8'd0, 32'd0, 5'd0, 1'b1,
                         '{ST_OK, 5'd0, 1'b0, 1'b1}});
        rows.push_back('{MODE_DISK_DONE, 8'd0, 32'd0, 5'd0, 1'b0, none});
        rows.push_back('{MODE_RELEASE, 8'd0, 32'd0, 5'd0, 1'b0, none});
        rows.push_back('{MODE_GET, 8'd0, 32'd0, 5'd0, 1'b0, none});
        rows.push_back('{MODE_UNPIN, 8'd0, 32'd0, 5'd0, 1'b0, none});
        rows.push_back('{MODE_RELEASE, 8'd0, 32'd0, 5'd0, 1'b0, none});
        rows.push_back('{MODE_PIN, 8'd0, 32'd0, 5'd1, 1'b0, none});
        rows.push_back('{MODE_UNPIN, 8'd0, 32'd0, 5'd1, 1'b0, none});
        rows.push_back('{MODE_SPARE6, 8'hAA, 32'h5555_AAAA, 5'd21, 1'b1,
                         '{ST_OK, 5'd21, 1'b0, 1'b0}});
        rows.push_back('{MODE_SPARE7, 8'h55, 32'hAAAA_5555, 5'd10, 1'b1,
                         '{ST_OK, 5'd10, 1'b0, 1'b0}});
        // rows go back to back, start stays high between them
        foreach (rows[i]) begin
            send_request(rows[i].mode, rows[i].device, rows[i].block, rows[i].slot,
                         rows[i].has_fixed, rows[i].fixed);
        end

        // count saturation: pin one slot 66 times, then drain
        for (int i = 0; i < 66; i++) begin
            send_request(MODE_PIN, 8'd0, 32'd0, 5'd7, 1'b0, none);
        end
        drop_start();
        drain();

        // random phases over several base values, extremes among them
        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_base(32'hFFFF_FFFF);
                1: write_base(32'h0);
                2: write_base($urandom);
                default: write_base(32'h8000_0000);
            endcase
            while (sent < RANDOM_REQUESTS * (phase + 1) / 4) begin
                burst = $urandom_range(1, 12);
                for (int k = 0; k < burst; k++) begin
                    random_request(m, d, b, s);
                    send_request(m, d, b, s, 1'b0, none);
                    sent++;
                end
                if ($urandom_range(0, 2) != 0) begin
                    drop_start();
                    repeat ($urandom_range(1, 40)) @(posedge i_clk);
                end
            end
            drop_start();
            // pause until everything is back, then configure again
            drain();
        end

        drain();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== lru_block_buffer_cache.f =====
+incdir+design
design/lbc_pkg.sv
design/lbc_ctrl.sv
design/lbc_datapath.sv
design/lru_block_buffer_cache.sv
test/tb_lru_block_buffer_cache.sv
